/* hw/rtl/ale_pkg.sv */
`default_nettype none

package ale_pkg;

    localparam int CAPACITY = 64;
    localparam int ADDR_W   = $clog2(CAPACITY);
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int POS_W    = 7;
    localparam int DATA_W   = 32;

    typedef enum logic [2:0] {
        F_INSERT     = 3'd0,
        F_REMOVE_AT  = 3'd1,
        F_REMOVE_VAL = 3'd2,
        F_FIND       = 3'd3,
        F_MODIFY     = 3'd4,
        F_MINMAX     = 3'd5,
        F_CLEAR      = 3'd6,
        F_NONE       = 3'd7
    } t_func;

    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_BADPOS   = 3'd1,
        ST_FULL     = 3'd2,
        ST_EMPTY    = 3'd3,
        ST_NOTHING  = 3'd4,
        ST_NOTFOUND = 3'd5
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_UP,
        S_DN,
        S_RD,
        S_RDW,
        S_SCAN,
        S_DONE
    } t_state;

    typedef struct packed {
        logic [2:0]               func;
        logic [POS_W-1:0]         position;
        logic signed [DATA_W-1:0] value;
    } t_in;

    typedef struct packed {
        logic [2:0]               status;
        logic signed [DATA_W-1:0] old_value;
        logic [POS_W-1:0]         found_position;
        logic signed [DATA_W-1:0] min_value;
        logic signed [DATA_W-1:0] max_value;
        logic [POS_W-1:0]         count;
        logic                     is_full;
        logic                     is_empty;
    } t_out;

    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] waddr;
        logic [DATA_W-1:0] wdata;
        logic              re;
        logic [ADDR_W-1:0] raddr;
    } t_mem_req;

endpackage

`default_nettype wire

/* hw/rtl/ale_ram.sv */
`default_nettype none

module ale_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

/* hw/rtl/ale_ctrl.sv */
`default_nettype none

module ale_ctrl
    import ale_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    input  wire t_in               i_in_data,
    output logic                   o_in_ready,
    input  wire logic [DATA_W-1:0] i_rdata,
    output t_mem_req               o_mem,
    output logic                   o_res_valid,
    output t_out                   o_res,
    input  wire logic              i_out_free
);

    t_state                   r_state, n_state;
    logic [CNT_W-1:0]         r_count, n_count;
    t_func                    r_func, n_func;
    logic [POS_W-1:0]         r_pos, n_pos;
    logic [DATA_W-1:0]        r_val, n_val;
    logic [ADDR_W-1:0]        r_ra, n_ra;
    logic [ADDR_W-1:0]        r_pa, n_pa;
    logic [CNT_W-1:0]         r_left, n_left;
    logic                     r_rv, n_rv;
    t_status                  r_status, n_status;
    logic [DATA_W-1:0]        r_old, n_old;
    logic [POS_W-1:0]         r_fpos, n_fpos;
    logic signed [DATA_W-1:0] r_min, n_min;
    logic signed [DATA_W-1:0] r_max, n_max;

    logic  accept;
    t_func in_func;
    logic  bad_pos;
    logic  is_empty;
    logic  is_full;
    logic  past_end;
    logic  walk_end;
    logic  match;

    assign accept   = i_in_valid && o_in_ready;
    assign in_func  = t_func'(i_in_data.func);
    assign bad_pos  = (i_in_data.position == '0) || (32'(i_in_data.position) > CAPACITY);
    assign is_empty = (r_count == '0);
    assign is_full  = (32'(r_count) >= CAPACITY);
    assign past_end = 32'(i_in_data.position) > 32'(r_count);
    assign walk_end = (r_left == '0) && !r_rv;
    assign match    = r_rv && (r_func != F_MINMAX) && (i_rdata == r_val);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_rv    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_rv    <= n_rv;
        end
    end

    always_ff @(posedge i_clk) begin
        r_func   <= n_func;
        r_pos    <= n_pos;
        r_val    <= n_val;
        r_ra     <= n_ra;
        r_pa     <= n_pa;
        r_left   <= n_left;
        r_status <= n_status;
        r_old    <= n_old;
        r_fpos   <= n_fpos;
        r_min    <= n_min;
        r_max    <= n_max;
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    unique case (in_func)
                        F_INSERT: begin
                            if (!bad_pos && !is_full && !past_end) begin
                                n_state = S_UP;
                            end else begin
                                n_state = S_DONE;
                            end
                        end
                        F_REMOVE_AT, F_MODIFY: begin
                            if (!bad_pos && !is_empty && !past_end) begin
                                n_state = S_RD;
                            end else begin
                                n_state = S_DONE;
                            end
                        end
                        F_REMOVE_VAL, F_FIND, F_MINMAX: begin
                            n_state = is_empty ? S_DONE : S_SCAN;
                        end
                        F_CLEAR, F_NONE: n_state = S_DONE;
                    endcase
                end
            end
            S_RD:  n_state = S_RDW;
            S_RDW: n_state = (r_func == F_MODIFY) ? S_DONE : S_DN;
            S_UP, S_DN: begin
                if (walk_end) begin
                    n_state = S_DONE;
                end
            end
            S_SCAN: begin
                if (match) begin
                    n_state = (r_func == F_FIND) ? S_DONE : S_DN;
                end else if (walk_end) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (i_out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        n_count  = r_count;
        n_func   = r_func;
        n_pos    = r_pos;
        n_val    = r_val;
        n_ra     = r_ra;
        n_pa     = r_pa;
        n_left   = r_left;
        n_rv     = 1'b0;
        n_status = r_status;
        n_old    = r_old;
        n_fpos   = r_fpos;
        n_min    = r_min;
        n_max    = r_max;
        o_mem    = '0;

        // shared sequential read walk: up walks downward, others upward
        if (r_state == S_UP || r_state == S_DN || r_state == S_SCAN) begin
            if (r_left != '0) begin
                o_mem.re    = 1'b1;
                o_mem.raddr = r_ra;
                n_rv        = 1'b1;
                n_pa        = r_ra;
                n_ra        = (r_state == S_UP) ? r_ra - 1'b1 : r_ra + 1'b1;
                n_left      = r_left - 1'b1;
            end
        end

        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_func   = in_func;
                    n_pos    = i_in_data.position;
                    n_val    = i_in_data.value;
                    n_status = ST_OK;
                    n_old    = '0;
                    n_fpos   = '0;
                    n_min    = '0;
                    n_max    = '0;
                    unique case (in_func)
                        F_INSERT: begin
                            if (bad_pos) begin
                                n_status = ST_BADPOS;
                            end else if (is_full) begin
                                n_status = ST_FULL;
                            end else if (!past_end) begin
                                n_ra   = ADDR_W'(r_count - 1'b1);
                                n_left = CNT_W'(32'(r_count) - 32'(i_in_data.position) + 1);
                            end else begin
                                o_mem.we    = 1'b1;
                                o_mem.waddr = ADDR_W'(r_count);
                                o_mem.wdata = i_in_data.value;
                                n_count     = r_count + 1'b1;
                            end
                        end
                        F_REMOVE_AT, F_MODIFY: begin
                            if (bad_pos) begin
                                n_status = ST_BADPOS;
                            end else if (is_empty) begin
                                n_status = ST_EMPTY;
                            end else if (past_end) begin
                                n_status = ST_NOTHING;
                            end
                        end
                        F_REMOVE_VAL, F_FIND, F_MINMAX: begin
                            if (is_empty) begin
                                n_status = ST_EMPTY;
                            end
                            n_ra   = '0;
                            n_left = r_count;
                        end
                        F_CLEAR: begin
                            if (is_empty) begin
                                n_status = ST_EMPTY;
                            end
                            n_count = '0;
                        end
                        F_NONE: begin
                        end
                    endcase
                end
            end
            S_RD: begin
                o_mem.re    = 1'b1;
                o_mem.raddr = ADDR_W'(r_pos - 1'b1);
            end
            S_RDW: begin
                n_old = i_rdata;
                if (r_func == F_MODIFY) begin
                    o_mem.we    = 1'b1;
                    o_mem.waddr = ADDR_W'(r_pos - 1'b1);
                    o_mem.wdata = r_val;
                end else begin
                    n_ra   = ADDR_W'(r_pos);
                    n_left = CNT_W'(32'(r_count) - 32'(r_pos));
                end
            end
            S_UP: begin
                if (r_rv) begin
                    o_mem.we    = 1'b1;
                    o_mem.waddr = r_pa + 1'b1;
                    o_mem.wdata = i_rdata;
                end else if (walk_end) begin
                    o_mem.we    = 1'b1;
                    o_mem.waddr = ADDR_W'(r_pos - 1'b1);
                    o_mem.wdata = r_val;
                    n_count     = r_count + 1'b1;
                end
            end
            S_DN: begin
                if (r_rv) begin
                    o_mem.we    = 1'b1;
                    o_mem.waddr = r_pa - 1'b1;
                    o_mem.wdata = i_rdata;
                end else if (walk_end) begin
                    n_count = r_count - 1'b1;
                end
            end
            S_SCAN: begin
                if (r_rv && r_func == F_MINMAX) begin
                    if (r_pa == '0) begin
                        n_min = i_rdata;
                        n_max = i_rdata;
                    end else begin
                        if ($signed(i_rdata) < r_min) begin
                            n_min = i_rdata;
                        end
                        if ($signed(i_rdata) > r_max) begin
                            n_max = i_rdata;
                        end
                    end
                end else if (match) begin
                    n_fpos = POS_W'(32'(r_pa) + 1);
                    if (r_func == F_REMOVE_VAL) begin
                        // drop the read in flight, start closing the gap
                        n_old  = i_rdata;
                        n_ra   = r_pa + 1'b1;
                        n_left = CNT_W'(32'(r_count) - 32'(r_pa) - 1);
                        n_rv   = 1'b0;
                    end
                end else if (walk_end && r_func != F_MINMAX) begin
                    n_status = ST_NOTFOUND;
                end
            end
            S_DONE: begin
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        o_in_ready           = (r_state == S_IDLE);
        o_res_valid          = (r_state == S_DONE);
        o_res.status         = r_status;
        o_res.old_value      = r_old;
        o_res.found_position = r_fpos;
        o_res.min_value      = r_min;
        o_res.max_value      = r_max;
        o_res.count          = POS_W'(r_count);
        o_res.is_full        = (32'(r_count) == CAPACITY);
        o_res.is_empty       = (r_count == '0);
    end

endmodule

`default_nettype wire

/* hw/rtl/array_list_engine.sv */
`default_nettype none

// channel   direction  payload  handshake
// in        input      t_in     i_in_valid / o_in_ready
// out       output     t_out    o_out_valid / i_out_ready
//
// One item at a time. Clear, errors and append go straight to the result; modify
// reads the entry and writes it back. Insert, remove and scans walk the list
// through the single entry memory, one read per cycle.
// Reset clears the count and control only; entry memory is not cleared.
// The result sits in an output register, so the next transfer in is taken
// while a finished result still waits on i_out_ready.

module array_list_engine
    import ale_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_in_valid,
    output logic      o_in_ready,
    input  wire t_in  i_in_data,
    output logic      o_out_valid,
    input  wire logic i_out_ready,
    output t_out      o_out_data
);

    t_mem_req          mem;
    logic [DATA_W-1:0] rdata;
    logic              res_valid;
    t_out              res;
    logic              out_free;
    logic              r_out_valid;
    t_out              r_out;

    assign out_free    = !r_out_valid || i_out_ready;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    ale_ram #(
        .WIDTH(DATA_W),
        .DEPTH(CAPACITY)
    ) u_ram (
        .i_clk  (i_clk),
        .i_we   (mem.we),
        .i_waddr(mem.waddr),
        .i_wdata(mem.wdata),
        .i_re   (mem.re),
        .i_raddr(mem.raddr),
        .o_rdata(rdata)
    );

    ale_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_in_data  (i_in_data),
        .o_in_ready (o_in_ready),
        .i_rdata    (rdata),
        .o_mem      (mem),
        .o_res_valid(res_valid),
        .o_res      (res),
        .i_out_free (out_free)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res_valid && out_free) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_valid && out_free) begin
            r_out <= res;
        end
    end

    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("transfer in taken while an item is still in work");

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (32'(o_out_data.count) <= CAPACITY))
        else $error("count above capacity");

    a_flags: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> ((o_out_data.is_empty == (o_out_data.count == '0)) &&
                         (o_out_data.is_full == (32'(o_out_data.count) == CAPACITY))))
        else $error("fill flags disagree with count");

    a_error_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.status != ST_OK) |->
            (o_out_data.old_value == '0 && o_out_data.found_position == '0))
        else $error("error result carries data");

endmodule

`default_nettype wire
